>>> hw/rtl/bsc_pkg.sv
// bsc_pkg: types and constants shared by the bitmap store blocks
// holds item structs, controller commands/status and the state encoding
// no dependencies
`default_nettype none

package bsc_pkg;

  localparam logic [2:0] CMD_TEST    = 3'd0;
  localparam logic [2:0] CMD_SET     = 3'd1;
  localparam logic [2:0] CMD_CLEAR   = 3'd2;
  localparam logic [2:0] CMD_COUNT   = 3'd3;
  localparam logic [2:0] CMD_COMPARE = 3'd4;
  localparam logic [2:0] CMD_WRITE   = 3'd5;

  localparam logic [6:0] ACTIVE_RESET = 7'd64;
  localparam logic [7:0] BIT0_MASK    = 8'h80;

  typedef struct packed {
    logic [2:0] cmd;
    logic       which_map;
    logic [8:0] bit_index;
    logic [5:0] byte_index;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic       bit_value;
    logic [9:0] set_count;
    logic [9:0] only_in_first;
    logic [9:0] only_in_second;
    logic       index_error;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic ctr_clr;
    logic ctr_inc;
    logic acc_clr;
    logic rd_bit;
    logic rd_walk;
    logic wr_bit;
    logic wr_byte;
    logic emit;
  } ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       err;
    logic       len_zero;
    logic       walk_last;
    logic       clr_last;
  } stat_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_READ,
    S_UPD,
    S_WALK,
    S_DRAIN,
    S_FIN
  } state_t;

  function automatic logic [3:0] ones8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 0; k < 8; k++) begin
      n = n + 4'(v[k]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bitmap_store_with_count.sv
// bitmap_store_with_count: top level, two bit maps with test/set/clear/count/compare/write
// instantiates bsc_ctrl and bsc_dpath; uses bsc_pkg
// command steps: test/set/clear decode, read, update; write byte, errors, unused codes and
// zero length count/compare decode, finish; other count/compare decode, walk, drain, finish
// throughput: next command accepted in the out_valid cycle; walks read one byte per cycle
// reset: synchronous; a clearing pass over all BYTES addresses zeroes both maps, busy held high
`default_nettype none

module bitmap_store_with_count #(
  parameter int BYTES = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire bsc_pkg::in_item_t  in_data,
  output logic                    out_valid,
  output bsc_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [6:0]         cfg_data
);
  import bsc_pkg::*;

  ctl_t  ctl;
  stat_t st;

  assign cfg_ready = 1'b1;

  bsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .st        (st),
    .ctl       (ctl)
  );

  bsc_dpath #(
    .BYTES (BYTES)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .ctl      (ctl),
    .st       (st),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

>>> hw/rtl/bsc_ctrl.sv
// bsc_ctrl: command sequencer for the bitmap store
// drives datapath commands from its status; uses bsc_pkg
`default_nettype none

module bsc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  output logic                 out_valid,
  input  wire bsc_pkg::stat_t  st,
  output bsc_pkg::ctl_t        ctl
);
  import bsc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= ctl.emit;
    end
  end

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        ctl.clr_wr  = 1'b1;
        ctl.ctr_inc = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        ctl.ctr_clr = 1'b1;
        ctl.acc_clr = 1'b1;
        unique case (st.cmd) inside
          CMD_TEST, CMD_SET, CMD_CLEAR: state_nxt = st.err ? S_FIN : S_READ;
          CMD_COUNT, CMD_COMPARE:       state_nxt = st.len_zero ? S_FIN : S_WALK;
          default:                      state_nxt = S_FIN;
        endcase
      end
      S_READ: begin
        ctl.rd_bit = 1'b1;
        state_nxt  = S_UPD;
      end
      S_UPD: begin
        ctl.emit   = 1'b1;
        ctl.wr_bit = (st.cmd == CMD_SET) || (st.cmd == CMD_CLEAR);
        state_nxt  = S_IDLE;
      end
      S_WALK: begin
        ctl.rd_walk = 1'b1;
        ctl.ctr_inc = 1'b1;
        if (st.walk_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        ctl.emit    = 1'b1;
        ctl.wr_byte = (st.cmd == CMD_WRITE) && !st.err;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> hw/rtl/bsc_dpath.sv
// bsc_dpath: bit map memories, walk counter, accumulators and result register
// executes commands from bsc_ctrl; uses bsc_pkg
`default_nettype none

module bsc_dpath #(
  parameter int BYTES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bsc_pkg::in_item_t in_data,
  input  wire logic              cfg_we,
  input  wire logic [6:0]        cfg_data,
  input  wire bsc_pkg::ctl_t     ctl,
  output bsc_pkg::stat_t         st,
  output bsc_pkg::out_item_t     out_data
);
  import bsc_pkg::*;

  localparam int AW = (BYTES > 1) ? $clog2(BYTES) : 1;
  localparam int CW = (AW > 7) ? AW : 7;
  localparam int XW = (AW > 6) ? AW : 6;
  localparam logic [12:0]   BYTES_L   = 13'(BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(BYTES - 1);

  logic [7:0] map_a [BYTES];
  logic [7:0] map_b [BYTES];

  logic [6:0]    active_r;
  in_item_t      item_r;
  logic [AW-1:0] ctr_r;
  logic [7:0]    rd_a_r, rd_b_r;
  logic          acc_vld_r;
  logic [9:0]    acc_cnt_r, acc_one_r, acc_two_r;
  out_item_t     out_r;

  logic [6:0]    len;
  logic [5:0]    bit_byte;
  logic          err;
  logic [XW-1:0] bit_addr_x, byte_addr_x;
  logic [AW-1:0] bit_addr, byte_addr, rd_addr, wr_addr;
  logic          rd_en, we_a, we_b;
  logic [7:0]    wr_data, mask, sel_rd;
  out_item_t     res;

  // active length saturated to the store depth
  assign len = (13'(active_r) > BYTES_L) ? BYTES_L[6:0] : active_r;

  assign bit_byte    = item_r.bit_index[8:3];
  assign bit_addr_x  = XW'(bit_byte);
  assign byte_addr_x = XW'(item_r.byte_index);
  assign bit_addr    = bit_addr_x[AW-1:0];
  assign byte_addr   = byte_addr_x[AW-1:0];
  assign mask        = BIT0_MASK >> item_r.bit_index[2:0];
  assign sel_rd      = item_r.which_map ? rd_b_r : rd_a_r;

  always_comb begin
    case (item_r.cmd) inside
      CMD_TEST, CMD_SET, CMD_CLEAR: err = ({1'b0, bit_byte} >= len);
      CMD_WRITE:                    err = ({1'b0, item_r.byte_index} >= len);
      default:                      err = 1'b0;
    endcase
  end

  always_comb begin
    st.cmd       = item_r.cmd;
    st.err       = err;
    st.len_zero  = (len == 7'd0);
    st.walk_last = (CW'(ctr_r) + CW'(1)) == CW'(len);
    st.clr_last  = (ctr_r == LAST_ADDR);
  end

  // memory port muxing
  assign rd_en   = ctl.rd_bit | ctl.rd_walk;
  assign rd_addr = ctl.rd_walk ? ctr_r : bit_addr;

  always_comb begin
    we_a    = 1'b0;
    we_b    = 1'b0;
    wr_addr = ctr_r;
    wr_data = 8'h00;
    if (ctl.clr_wr) begin
      we_a = 1'b1;
      we_b = 1'b1;
    end else if (ctl.wr_bit) begin
      we_a    = !item_r.which_map;
      we_b    = item_r.which_map;
      wr_addr = bit_addr;
      wr_data = (item_r.cmd == CMD_SET) ? (sel_rd | mask) : (sel_rd & ~mask);
    end else if (ctl.wr_byte) begin
      we_a    = !item_r.which_map;
      we_b    = item_r.which_map;
      wr_addr = byte_addr;
      wr_data = item_r.byte_value;
    end
  end

  always_ff @(posedge clk) begin
    if (we_a) begin
      map_a[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= map_a[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      map_b[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_b_r <= map_b[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= ACTIVE_RESET;
      ctr_r     <= '0;
      acc_vld_r <= 1'b0;
    end else begin
      acc_vld_r <= ctl.rd_walk;
      if (cfg_we) begin
        active_r <= cfg_data;
      end
      if (ctl.ctr_clr) begin
        ctr_r <= '0;
      end else if (ctl.ctr_inc) begin
        ctr_r <= ctr_r + AW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_r <= in_data;
    end
    if (ctl.acc_clr) begin
      acc_cnt_r <= '0;
      acc_one_r <= '0;
      acc_two_r <= '0;
    end else if (acc_vld_r) begin
      acc_cnt_r <= acc_cnt_r + 10'(ones8(sel_rd));
      acc_one_r <= acc_one_r + 10'(ones8(rd_a_r & ~rd_b_r));
      acc_two_r <= acc_two_r + 10'(ones8(rd_b_r & ~rd_a_r));
    end
    if (ctl.emit) begin
      out_r <= res;
    end
  end

  always_comb begin
    res.bit_value      = !err && (((item_r.cmd == CMD_TEST) && |(sel_rd & mask)) ||
                                  (item_r.cmd == CMD_SET));
    res.set_count      = (item_r.cmd == CMD_COUNT)   ? acc_cnt_r : 10'd0;
    res.only_in_first  = (item_r.cmd == CMD_COMPARE) ? acc_one_r : 10'd0;
    res.only_in_second = (item_r.cmd == CMD_COMPARE) ? acc_two_r : 10'd0;
    res.index_error    = err;
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

>>> hw/rtl/bsc_check.sv
// bsc_check: port level checks for bitmap_store_with_count
// bound to the top level; uses bsc_pkg
`default_nettype none

module bsc_check (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire bsc_pkg::out_item_t out_data
);
  import bsc_pkg::*;

  // an accepted beat keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accept");

  // results never come back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // the result beat arrives with the block ready for the next command
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

  // an index error carries no other result
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.index_error) |->
      (!out_data.bit_value && out_data.set_count == 10'd0 &&
       out_data.only_in_first == 10'd0 && out_data.only_in_second == 10'd0))
    else $error("index error with nonzero result fields");

endmodule

bind bitmap_store_with_count bsc_check u_check (.*);

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench for bitmap_store_with_count: directed and random commands, checked beat by beat
// against a behavioral model of both bit maps; depends on bsc_pkg and the rtl top level
module testbench;
  import bsc_pkg::*;

  localparam int MAP_BYTES = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_data;
  logic out_valid;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [6:0] cfg_data;

  logic [7:0] first_bits[MAP_BYTES];
  logic [7:0] second_bits[MAP_BYTES];
  int active_len;
  out_item_t pending_results[$];
  out_item_t want_result;
  int mismatch_count;
  int cycle_count;
  int burst_left;

  bitmap_store_with_count #(.BYTES(MAP_BYTES)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic out_item_t predict_bitmap_result(input in_item_t it);
    out_item_t res;
    logic [7:0] mask;
    logic [7:0] cur;
    logic [5:0] idx;
    int len;
    int ones_a;
    int ones_b;
    res = '0;
    ones_a = 0;
    ones_b = 0;
    len = (active_len > MAP_BYTES) ? MAP_BYTES : active_len;
    mask = BIT0_MASK >> it.bit_index[2:0];
    idx = (it.cmd == CMD_WRITE) ? it.byte_index : it.bit_index[8:3];
    cur = it.which_map ? second_bits[idx] : first_bits[idx];
    case (it.cmd)
      CMD_TEST, CMD_SET, CMD_CLEAR, CMD_WRITE: begin
        if (int'(idx) >= len) begin
          res.index_error = 1'b1;
        end else begin
          case (it.cmd)
            CMD_TEST: res.bit_value = |(cur & mask);
            CMD_SET: begin
              cur = cur | mask;
              res.bit_value = 1'b1;
            end
            CMD_CLEAR: cur = cur & ~mask;
            default: cur = it.byte_value;
          endcase
          if (it.which_map) second_bits[idx] = cur;
          else first_bits[idx] = cur;
        end
      end
      CMD_COUNT: begin
        for (int i = 0; i < len; i++) begin
          ones_a += $countones(it.which_map ? second_bits[i] : first_bits[i]);
        end
        res.set_count = 10'(ones_a);
      end
      CMD_COMPARE: begin
        for (int i = 0; i < len; i++) begin
          ones_a += $countones(first_bits[i] & ~second_bits[i]);
          ones_b += $countones(second_bits[i] & ~first_bits[i]);
        end
        res.only_in_first = 10'(ones_a);
        res.only_in_second = 10'(ones_b);
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic in_item_t make_command(input logic [2:0] cmd, input logic which,
                                            input logic [8:0] bit_no, input logic [5:0] byte_no,
                                            input logic [7:0] value);
    in_item_t it;
    it.cmd = cmd;
    it.which_map = which;
    it.bit_index = bit_no;
    it.byte_index = byte_no;
    it.byte_value = value;
    return it;
  endfunction

  function automatic in_item_t random_command(input int len);
    in_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 18) it.cmd = CMD_TEST;
    else if (pick < 33) it.cmd = CMD_SET;
    else if (pick < 48) it.cmd = CMD_CLEAR;
    else if (pick < 58) it.cmd = CMD_COUNT;
    else if (pick < 68) it.cmd = CMD_COMPARE;
    else if (pick < 96) it.cmd = CMD_WRITE;
    else it.cmd = (pick < 98) ? CMD_SPARE_A : CMD_SPARE_B;
    it.which_map = 1'($urandom_range(0, 1));
    if (len > 0 && $urandom_range(0, 9) != 0) begin
      it.bit_index = 9'($urandom_range(0, 8 * len - 1));
      it.byte_index = 6'($urandom_range(0, len - 1));
    end else begin
      it.bit_index = 9'($urandom_range(0, 511));
      it.byte_index = 6'($urandom_range(0, 63));
    end
    case ($urandom_range(0, 9))
      0: it.byte_value = 8'h00;
      1: it.byte_value = 8'hff;
      default: it.byte_value = 8'($urandom_range(0, 255));
    endcase
    return it;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 40) begin
      $display("mismatch on %0s: got %0d, want %0d (cycle %0d)", what, got, want, cycle_count);
    end
    mismatch_count++;
  endtask

  task automatic send_command(input in_item_t it);
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pending_results.push_back(predict_bitmap_result(it));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic drain_results(input int settle);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_active_bytes(input logic [6:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    active_len = int'(value);
  endtask

  task automatic test_full_length();
    write_active_bytes(7'd64);
    send_command(make_command(CMD_TEST, 1'b0, 9'd0, 6'd63, 8'hff));
    send_command(make_command(CMD_SET, 1'b0, 9'd0, 6'd0, 8'h00));
    send_command(make_command(CMD_TEST, 1'b0, 9'd0, 6'd0, 8'h00));
    send_command(make_command(CMD_SET, 1'b1, 9'd511, 6'd63, 8'hff));
    send_command(make_command(CMD_TEST, 1'b1, 9'd511, 6'd0, 8'h00));
    send_command(make_command(CMD_TEST, 1'b1, 9'd504, 6'd0, 8'h00));
    send_command(make_command(CMD_WRITE, 1'b0, 9'd0, 6'd63, 8'hff));
    send_command(make_command(CMD_WRITE, 1'b1, 9'd511, 6'd0, 8'h5a));
    send_command(make_command(CMD_COUNT, 1'b0, 9'd0, 6'd0, 8'h00));
    send_command(make_command(CMD_COUNT, 1'b1, 9'd0, 6'd0, 8'h00));
    send_command(make_command(CMD_COMPARE, 1'b1, 9'd511, 6'd63, 8'hff));
    send_command(make_command(CMD_CLEAR, 1'b0, 9'd511, 6'd0, 8'h00));
    send_command(make_command(CMD_CLEAR, 1'b1, 9'd511, 6'd0, 8'h00));
    send_command(make_command(CMD_SPARE_A, 1'b1, 9'd511, 6'd63, 8'hff));
    send_command(make_command(CMD_SPARE_B, 1'b0, 9'd7, 6'd1, 8'h01));
    drain_results(8);
  endtask

  task automatic test_one_byte_length();
    write_active_bytes(7'd1);
    send_command(make_command(CMD_SET, 1'b0, 9'd7, 6'd0, 8'h00));
    send_command(make_command(CMD_SET, 1'b0, 9'd8, 6'd0, 8'h00));
    send_command(make_command(CMD_WRITE, 1'b1, 9'd0, 6'd1, 8'hff));
    send_command(make_command(CMD_WRITE, 1'b1, 9'd0, 6'd0, 8'hff));
    send_command(make_command(CMD_TEST, 1'b1, 9'd511, 6'd0, 8'h00));
    send_command(make_command(CMD_COUNT, 1'b1, 9'd0, 6'd0, 8'h00));
    send_command(make_command(CMD_COMPARE, 1'b0, 9'd0, 6'd0, 8'h00));
    drain_results(8);
  endtask

  task automatic test_zero_length();
    write_active_bytes(7'd0);
    send_command(make_command(CMD_SET, 1'b0, 9'd0, 6'd0, 8'h00));
    send_command(make_command(CMD_WRITE, 1'b1, 9'd0, 6'd0, 8'hff));
    send_command(make_command(CMD_COUNT, 1'b0, 9'd0, 6'd0, 8'h00));
    send_command(make_command(CMD_COMPARE, 1'b0, 9'd0, 6'd0, 8'h00));
    drain_results(8);
  endtask

  task automatic test_random_traffic(input logic [6:0] active, input int n_items);
    int len;
    write_active_bytes(active);
    len = (int'(active) > MAP_BYTES) ? MAP_BYTES : int'(active);
    for (int k = 0; k < n_items; k++) begin
      send_command(random_command(len));
      if ($urandom_range(0, 149) == 0) drain_results(2);
    end
    drain_results(8);
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want_result = pending_results.pop_front();
        if (out_data.bit_value !== want_result.bit_value)
          report_mismatch("bit_value", int'(out_data.bit_value), int'(want_result.bit_value));
        if (out_data.set_count !== want_result.set_count)
          report_mismatch("set_count", int'(out_data.set_count), int'(want_result.set_count));
        if (out_data.only_in_first !== want_result.only_in_first)
          report_mismatch("only_in_first", int'(out_data.only_in_first),
                          int'(want_result.only_in_first));
        if (out_data.only_in_second !== want_result.only_in_second)
          report_mismatch("only_in_second", int'(out_data.only_in_second),
                          int'(want_result.only_in_second));
        if (out_data.index_error !== want_result.index_error)
          report_mismatch("index_error", int'(out_data.index_error),
                          int'(want_result.index_error));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** bitmap_store_with_count: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    mismatch_count = 0;
    cycle_count = 0;
    burst_left = 0;
    active_len = int'(ACTIVE_RESET);
    for (int i = 0; i < MAP_BYTES; i++) begin
      first_bits[i] = 8'h00;
      second_bits[i] = 8'h00;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_full_length();
    test_one_byte_length();
    test_zero_length();
    test_random_traffic(7'd64, 350);
    test_random_traffic(7'd127, 300);
    test_random_traffic(7'd1, 200);
    test_random_traffic(7'd0, 100);
    test_random_traffic(7'($urandom_range(2, 63)), 350);
    test_random_traffic(7'($urandom_range(65, 126)), 150);
    test_random_traffic(7'd64, 350);

    drain_results(80);
    if (mismatch_count == 0) begin
      $display("** bitmap_store_with_count: PASSED **");
    end else begin
      $display("** bitmap_store_with_count: FAILED **");
    end
    $finish;
  end

endmodule

>>> bitmap_store_with_count.f
hw/rtl/bsc_pkg.sv
hw/rtl/bsc_ctrl.sv
hw/rtl/bsc_dpath.sv
hw/rtl/bitmap_store_with_count.sv
hw/rtl/bsc_check.sv
tb/sv/testbench.sv
